// File: rtl/core/ssg_pkg.sv
// Shared types, constants and the substitution rule table for the
// substitution sequence generator. No dependencies.
package ssg_pkg;

    localparam int TAPE_DEPTH = 256;
    localparam int ADDR_W     = $clog2(TAPE_DEPTH);
    localparam int HEAD_W     = $clog2(TAPE_DEPTH + 1);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef logic [2:0] t_sym;

    localparam t_sym SYM_A = 3'd0;
    localparam t_sym SYM_B = 3'd1;
    localparam t_sym SYM_C = 3'd2;
    localparam t_sym SYM_D = 3'd3;
    localparam t_sym SYM_E = 3'd4;

    typedef enum logic [3:0] {
        RULE_FIB     = 4'd0,
        RULE_TRIB    = 4'd1,
        RULE_FOURB   = 4'd2,
        RULE_FIVEB   = 4'd3,
        RULE_TESTBON = 4'd4,
        RULE_MORSE   = 4'd5,
        RULE_CANTOR  = 4'd6,
        RULE_RUDIN   = 4'd7,
        RULE_BAUM    = 4'd8,
        RULE_NONAUTO = 4'd9
    } t_rule;

    // Register index of the configuration port.
    localparam logic REG_RULE_SELECT = 1'b0;

    // Expansion of one symbol: a count of zero means no rule applies.
    typedef struct packed {
        logic [1:0] cnt;
        t_sym       s0;
        t_sym       s1;
        t_sym       s2;
    } t_expansion;

    // Tape read request from the front to the expander.
    typedef struct packed {
        logic              valid;
        logic              seed;
        logic [ADDR_W-1:0] addr;
    } t_tape_req;

    // One emitted symbol.
    typedef struct packed {
        t_sym symbol;
        logic last;
    } t_out_word;

    function automatic t_expansion mk_exp(input logic [1:0] cnt, input t_sym s0,
                                          input t_sym s1, input t_sym s2);
        t_expansion e;
        e.cnt = cnt;
        e.s0  = s0;
        e.s1  = s1;
        e.s2  = s2;
        return e;
    endfunction

    function automatic t_expansion rule_lookup(input logic [3:0] rule, input t_sym sym);
        t_expansion e;
        logic       known;
        e     = mk_exp(2'd0, SYM_A, SYM_A, SYM_A);
        known = (sym <= SYM_E);
        unique case (rule)
            RULE_FIB: begin
                if (sym == SYM_A)  e = mk_exp(2'd2, SYM_A, SYM_B, SYM_A);
                else if (known)    e = mk_exp(2'd1, SYM_A, SYM_A, SYM_A);
            end
            RULE_TRIB: begin
                unique case (sym)
                    SYM_A:   e = mk_exp(2'd2, SYM_A, SYM_B, SYM_A);
                    SYM_B:   e = mk_exp(2'd2, SYM_A, SYM_C, SYM_A);
                    SYM_C:   e = mk_exp(2'd1, SYM_B, SYM_A, SYM_A);
                    default: e = mk_exp(2'd0, SYM_A, SYM_A, SYM_A);
                endcase
            end
            RULE_FOURB: begin
                unique case (sym)
                    SYM_A:   e = mk_exp(2'd2, SYM_A, SYM_B, SYM_A);
                    SYM_B:   e = mk_exp(2'd2, SYM_A, SYM_C, SYM_A);
                    SYM_C:   e = mk_exp(2'd2, SYM_B, SYM_D, SYM_A);
                    SYM_D:   e = mk_exp(2'd1, SYM_C, SYM_A, SYM_A);
                    default: e = mk_exp(2'd0, SYM_A, SYM_A, SYM_A);
                endcase
            end
            RULE_FIVEB: begin
                unique case (sym)
                    SYM_A:   e = mk_exp(2'd2, SYM_A, SYM_B, SYM_A);
                    SYM_B:   e = mk_exp(2'd2, SYM_A, SYM_C, SYM_A);
                    SYM_C:   e = mk_exp(2'd2, SYM_B, SYM_D, SYM_A);
                    SYM_D:   e = mk_exp(2'd2, SYM_C, SYM_E, SYM_A);
                    SYM_E:   e = mk_exp(2'd1, SYM_D, SYM_A, SYM_A);
                    default: e = mk_exp(2'd0, SYM_A, SYM_A, SYM_A);
                endcase
            end
            RULE_TESTBON: begin
                unique case (sym)
                    SYM_A:   e = mk_exp(2'd3, SYM_A, SYM_A, SYM_B);
                    SYM_B:   e = mk_exp(2'd1, SYM_C, SYM_A, SYM_A);
                    SYM_C:   e = mk_exp(2'd3, SYM_A, SYM_A, SYM_C);
                    default: e = mk_exp(2'd0, SYM_A, SYM_A, SYM_A);
                endcase
            end
            RULE_MORSE: begin
                if (sym == SYM_A)  e = mk_exp(2'd2, SYM_A, SYM_B, SYM_A);
                else if (known)    e = mk_exp(2'd2, SYM_B, SYM_A, SYM_A);
            end
            RULE_CANTOR: begin
                if (sym == SYM_A)  e = mk_exp(2'd3, SYM_A, SYM_B, SYM_A);
                else if (known)    e = mk_exp(2'd3, SYM_B, SYM_B, SYM_B);
            end
            RULE_RUDIN: begin
                unique case (sym)
                    SYM_A:   e = mk_exp(2'd2, SYM_A, SYM_B, SYM_A);
                    SYM_B:   e = mk_exp(2'd2, SYM_A, SYM_C, SYM_A);
                    SYM_C:   e = mk_exp(2'd2, SYM_D, SYM_B, SYM_A);
                    SYM_D:   e = mk_exp(2'd2, SYM_D, SYM_C, SYM_A);
                    default: e = mk_exp(2'd0, SYM_A, SYM_A, SYM_A);
                endcase
            end
            RULE_BAUM: begin
                unique case (sym)
                    SYM_A:   e = mk_exp(2'd2, SYM_A, SYM_B, SYM_A);
                    SYM_B:   e = mk_exp(2'd2, SYM_C, SYM_B, SYM_A);
                    SYM_C:   e = mk_exp(2'd2, SYM_B, SYM_D, SYM_A);
                    SYM_D:   e = mk_exp(2'd2, SYM_D, SYM_D, SYM_A);
                    default: e = mk_exp(2'd0, SYM_A, SYM_A, SYM_A);
                endcase
            end
            RULE_NONAUTO: begin
                unique case (sym)
                    SYM_A:   e = mk_exp(2'd2, SYM_A, SYM_B, SYM_A);
                    SYM_B:   e = mk_exp(2'd2, SYM_C, SYM_B, SYM_A);
                    SYM_C:   e = mk_exp(2'd1, SYM_B, SYM_A, SYM_A);
                    default: e = mk_exp(2'd0, SYM_A, SYM_A, SYM_A);
                endcase
            end
            default: e = mk_exp(2'd0, SYM_A, SYM_A, SYM_A);
        endcase
        return e;
    endfunction

endpackage

// File: rtl/core/ssg_front.sv
// Front end: accepts ticks, tracks the read head and issues tape reads.
// Depends on ssg_pkg.
module ssg_front
    import ssg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_restart,
    input  logic      i_back_ready,
    output logic      o_stall,
    output t_tape_req o_req
);

    logic [HEAD_W-1:0] r_rd_head;
    logic [HEAD_W-1:0] n_rd_head;
    logic              accept;
    logic              exhausted;

    assign o_stall   = !i_back_ready;
    assign accept    = i_valid && i_back_ready;
    assign exhausted = (r_rd_head >= HEAD_W'(TAPE_DEPTH));

    // A restart reads position zero, flagged as a seed so symbol a is used.
    always_comb begin
        o_req.valid = accept && (i_restart || !exhausted);
        o_req.seed  = i_restart;
        o_req.addr  = i_restart ? '0 : r_rd_head[ADDR_W-1:0];
    end

    always_comb begin
        n_rd_head = r_rd_head;
        if (accept && i_restart) begin
            n_rd_head = HEAD_W'(1);
        end else if (accept && !exhausted) begin
            n_rd_head = r_rd_head + HEAD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_head <= HEAD_W'(TAPE_DEPTH);
        end else begin
            r_rd_head <= n_rd_head;
        end
    end

endmodule

// File: rtl/core/ssg_expand.sv
// Back end: holds the tape, expands each fetched symbol by the selected
// rule, one word per cycle while the queue has room, writes them back. Depends on ssg_pkg.
module ssg_expand
    import ssg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tape_req  i_req,
    input  logic [3:0] i_rule,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_out_word  o_word
);

    t_sym              r_tape [TAPE_DEPTH];
    t_sym              r_rd_data;
    logic              r_fwd_hit;
    t_sym              r_fwd_data;
    logic              r_busy;
    logic              r_seed;
    logic [1:0]        r_idx;
    logic [HEAD_W-1:0] r_wr_head;
    logic [HEAD_W-1:0] n_wr_head;

    t_sym              cur_sym;
    t_expansion        exp_q;
    logic              is_last;
    logic              done;
    logic              we;
    logic [ADDR_W-1:0] waddr;

    // A word written in the same cycle as the read is forwarded.
    assign cur_sym = r_seed ? SYM_A : (r_fwd_hit ? r_fwd_data : r_rd_data);
    assign exp_q   = rule_lookup(i_rule, cur_sym);
    assign is_last = (r_idx == exp_q.cnt - 2'd1);
    assign o_push  = r_busy && (exp_q.cnt != 2'd0) && !i_q_full;
    assign done    = r_busy && ((exp_q.cnt == 2'd0) || (o_push && is_last));
    assign o_ready = !r_busy || done;

    always_comb begin
        unique case (r_idx)
            2'd0:    o_word.symbol = exp_q.s0;
            2'd1:    o_word.symbol = exp_q.s1;
            default: o_word.symbol = exp_q.s2;
        endcase
        o_word.last = is_last;
    end

    assign we    = o_push && (r_wr_head < HEAD_W'(TAPE_DEPTH));
    assign waddr = r_wr_head[ADDR_W-1:0];

    always_comb begin
        n_wr_head = r_wr_head;
        if (i_req.valid && i_req.seed) begin
            n_wr_head = '0;
        end else if (we) begin
            n_wr_head = r_wr_head + HEAD_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_tape[waddr] <= o_word.symbol;
        end
        if (i_req.valid) begin
            r_rd_data  <= r_tape[i_req.addr];
            r_fwd_hit  <= we && (waddr == i_req.addr);
            r_fwd_data <= o_word.symbol;
            r_seed     <= i_req.seed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= 2'd0;
            r_wr_head <= '0;
        end else begin
            r_wr_head <= n_wr_head;
            if (i_req.valid) begin
                r_busy <= 1'b1;
                r_idx  <= 2'd0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (o_push) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

endmodule

// File: rtl/core/ssg_outq.sv
// Output queue: a few words between the expander and the result channel,
// so the expander keeps working while the receiver stalls. Depends on ssg_pkg.
module ssg_outq
    import ssg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_word i_word,
    output logic      o_full,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_word
);

    t_out_word             r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr_ptr;
    logic [OUTQ_PTR_W-1:0] r_rd_ptr;
    logic [OUTQ_CNT_W-1:0] r_count;
    logic                  pop;

    assign o_full  = (r_count == OUTQ_CNT_W'(OUTQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUTQ_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OUTQ_PTR_W'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + OUTQ_CNT_W'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - OUTQ_CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/core/substitution_sequence_generator_core.sv
// Substitution sequence generator: a tick channel in, a symbol channel out
// and an APB-style register for the rule. Depends on ssg_pkg and the modules
// ssg_front, ssg_expand and ssg_outq.
//
// Usage:
//   Each word on the input channel (i_valid, o_stall, i_restart) is one tick.
//   A tick with i_restart high seeds the tape with symbol a and clears both
//   heads first. A tick reads the symbol at the read head and produces one
//   to three words on the output channel (o_valid, i_stall, o_symbol,
//   o_last); o_last marks the final word of the tick. Ticks on an exhausted
//   tape, or on a symbol without a rule, produce nothing.
//   A tick's symbol is registered at the tape read and its first word then
//   in the output queue. The expander takes the next tick once it pushes the
//   last word of the current one, or at once for a tick without words; the
//   single tape write port takes one word at a time. Reset leaves the tape
//   exhausted until the first restart and the rule at Fibonacci. A stalled
//   receiver fills the four-word output queue, after which the expander and
//   then the tick channel stall. rule_select sits at byte address 0; the user
//   must see it written only while idle, which the block does not enforce.
module substitution_sequence_generator_core
    import ssg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_symbol,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0] r_rule;
    t_tape_req  req;
    logic       back_ready;
    logic       q_full;
    logic       push;
    t_out_word  push_word;
    t_out_word  out_word;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RULE_SELECT) ? {28'd0, r_rule} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule <= RULE_FIB;
        end else if (psel && penable && pwrite && (paddr[2] == REG_RULE_SELECT)) begin
            r_rule <= pwdata[3:0];
        end
    end

    ssg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_restart    (i_restart),
        .i_back_ready (back_ready),
        .o_stall      (o_stall),
        .o_req        (req)
    );

    ssg_expand u_expand (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_rule   (r_rule),
        .i_q_full (q_full),
        .o_ready  (back_ready),
        .o_push   (push),
        .o_word   (push_word)
    );

    ssg_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_full  (q_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (out_word)
    );

    assign o_symbol = out_word.symbol;
    assign o_last   = out_word.last;

endmodule

// File: tb/ssg_symbol_checker.sv
// Symbol checker for the substitution sequence generator: watches the tick,
// symbol and register channels, predicts every symbol word and compares it.
// Depends on ssg_pkg for the symbol codes, rule codes and word type.
module ssg_symbol_checker
    import ssg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tick_valid,
    input  logic        i_tick_stall,
    input  logic        i_restart,
    input  logic        i_word_valid,
    input  logic        i_word_stall,
    input  logic [2:0]  i_symbol,
    input  logic        i_last,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] RULE_ADDR = {REG_RULE_SELECT, 2'b00};
    localparam int         PRINT_CAP = 40;

    // Replacement of one symbol; a length of zero means the symbol has no rule.
    typedef struct packed {
        logic [1:0] len;
        t_sym       s0;
        t_sym       s1;
        t_sym       s2;
    } t_growth;

    t_sym       tape [TAPE_DEPTH];
    int         read_head;
    int         write_head;
    logic [3:0] rule_sel;
    t_out_word  due_words [$];

    initial begin
        o_mismatches    = 0;
        o_pending       = 0;
        o_words_checked = 0;
    end

    function automatic t_growth substitute(input logic [3:0] rule, input t_sym sym);
        t_growth g;
        g = {2'd0, SYM_A, SYM_A, SYM_A};
        case (rule)
            RULE_FIB, RULE_MORSE, RULE_CANTOR: begin
                if (sym == SYM_A) begin
                    if (rule == RULE_CANTOR) g = {2'd3, SYM_A, SYM_B, SYM_A};
                    else                     g = {2'd2, SYM_A, SYM_B, SYM_A};
                end else if (sym <= SYM_E) begin
                    if (rule == RULE_FIB)        g = {2'd1, SYM_A, SYM_A, SYM_A};
                    else if (rule == RULE_MORSE) g = {2'd2, SYM_B, SYM_A, SYM_A};
                    else                         g = {2'd3, SYM_B, SYM_B, SYM_B};
                end
            end
            RULE_TRIB, RULE_FOURB, RULE_FIVEB: begin
                // The n-bonacci family shares its first rules; the last symbol
                // of each alphabet maps back to the one below it.
                case (sym)
                    SYM_A: g = {2'd2, SYM_A, SYM_B, SYM_A};
                    SYM_B: g = {2'd2, SYM_A, SYM_C, SYM_A};
                    SYM_C: begin
                        if (rule == RULE_TRIB) g = {2'd1, SYM_B, SYM_A, SYM_A};
                        else                   g = {2'd2, SYM_B, SYM_D, SYM_A};
                    end
                    SYM_D: begin
                        if (rule == RULE_FOURB)      g = {2'd1, SYM_C, SYM_A, SYM_A};
                        else if (rule == RULE_FIVEB) g = {2'd2, SYM_C, SYM_E, SYM_A};
                    end
                    SYM_E: begin
                        if (rule == RULE_FIVEB) g = {2'd1, SYM_D, SYM_A, SYM_A};
                    end
                    default: ;
                endcase
            end
            RULE_TESTBON: begin
                case (sym)
                    SYM_A:   g = {2'd3, SYM_A, SYM_A, SYM_B};
                    SYM_B:   g = {2'd1, SYM_C, SYM_A, SYM_A};
                    SYM_C:   g = {2'd3, SYM_A, SYM_A, SYM_C};
                    default: ;
                endcase
            end
            RULE_RUDIN: begin
                case (sym)
                    SYM_A:   g = {2'd2, SYM_A, SYM_B, SYM_A};
                    SYM_B:   g = {2'd2, SYM_A, SYM_C, SYM_A};
                    SYM_C:   g = {2'd2, SYM_D, SYM_B, SYM_A};
                    SYM_D:   g = {2'd2, SYM_D, SYM_C, SYM_A};
                    default: ;
                endcase
            end
            RULE_BAUM, RULE_NONAUTO: begin
                case (sym)
                    SYM_A: g = {2'd2, SYM_A, SYM_B, SYM_A};
                    SYM_B: g = {2'd2, SYM_C, SYM_B, SYM_A};
                    SYM_C: begin
                        if (rule == RULE_BAUM) g = {2'd2, SYM_B, SYM_D, SYM_A};
                        else                   g = {2'd1, SYM_B, SYM_A, SYM_A};
                    end
                    SYM_D: begin
                        if (rule == RULE_BAUM) g = {2'd2, SYM_D, SYM_D, SYM_A};
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return g;
    endfunction

    task automatic report_mismatch(input string what);
        // Every mismatch counts; only the first PRINT_CAP are printed to keep logs short.
        if (o_mismatches < PRINT_CAP) $display("%0t ns mismatch: %s", $realtime, what);
        o_mismatches++;
    endtask

    task automatic clear_state();
        for (int i = 0; i < TAPE_DEPTH; i++) tape[i] = SYM_A;
        read_head  = TAPE_DEPTH;
        write_head = 0;
        rule_sel   = RULE_FIB;
        due_words.delete();
    endtask

    task automatic advance_tape(input logic restart);
        t_sym      sym;
        t_sym      s;
        t_growth   g;
        t_out_word w;
        if (restart) begin
            tape[0]    = SYM_A;
            read_head  = 0;
            write_head = 0;
        end
        if (read_head < TAPE_DEPTH) begin
            sym = tape[read_head];
            read_head++;
            g = substitute(rule_sel, sym);
            for (int k = 0; k < int'(g.len); k++) begin
                s = (k == 0) ? g.s0 : (k == 1) ? g.s1 : g.s2;
                // Once the tape is full the word is still sent, just not stored.
                if (write_head < TAPE_DEPTH) begin
                    tape[write_head] = s;
                    write_head++;
                end
                w.symbol = s;
                w.last   = (k + 1 == int'(g.len));
                due_words.push_back(w);
            end
        end
    endtask

    task automatic check_word();
        t_out_word want;
        if (due_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word symbol %0d last %0b", i_symbol, i_last));
        end else begin
            want = due_words.pop_front();
            o_words_checked++;
            if (i_symbol !== want.symbol)
                report_mismatch($sformatf("word %0d symbol %0d, predicted %0d",
                                          o_words_checked, i_symbol, want.symbol));
            if (i_last !== want.last)
                report_mismatch($sformatf("word %0d last %0b, predicted %0b",
                                          o_words_checked, i_last, want.last));
        end
    endtask

    // Words leave through the read and queue registers, so output words are
    // checked before the tick accepted at the same edge is predicted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_word_valid && !i_word_stall) check_word();
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == RULE_ADDR)
                rule_sel = i_pwdata[3:0];
            if (i_tick_valid && !i_tick_stall) advance_tape(i_restart);
        end
        o_pending = due_words.size();
    end

endmodule

// File: tb/substitution_sequence_generator_core_test.sv
// Top of the substitution sequence generator test: clock, reset, tick and
// register stimulus, receiver stalls and the verdict. Depends on ssg_pkg,
// the core and ssg_symbol_checker.
module substitution_sequence_generator_core_test;
    import ssg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CLK_PERIOD     = 10;
    localparam int         RESET_CYCLES   = 7;
    localparam int         SETTLE_CYCLES  = 6;
    localparam int         LONG_HOLD      = 60;
    localparam int         FILL_TICKS     = 87;
    localparam int         RANDOM_TICKS   = 14;
    localparam int         QUIET_TAIL     = 6;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam logic [2:0] RULE_ADDR      = {REG_RULE_SELECT, 2'b00};
    localparam logic [3:0] RULE_UNUSED_LO = 4'd10;
    localparam logic [3:0] RULE_UNUSED_HI = 4'd15;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic        i_restart = 1'b0;
    logic        i_stall   = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_symbol;
    logic        o_last;
    logic [31:0] prdata;
    logic        pready;

    int   mismatches;
    int   pending;
    int   words_checked;
    int   ticks_sent     = 0;
    int   rule_writes    = 0;
    int   idle_cycles    = 0;
    logic quiet          = 1'b0;
    logic long_hold_req  = 1'b0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    substitution_sequence_generator_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_restart (i_restart),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_symbol  (o_symbol),
        .o_last    (o_last),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    ssg_symbol_checker symbol_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tick_valid    (i_valid),
        .i_tick_stall    (o_stall),
        .i_restart       (i_restart),
        .i_word_valid    (o_valid),
        .i_word_stall    (i_stall),
        .i_symbol        (o_symbol),
        .i_last          (o_last),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_words_checked (words_checked)
    );

    // Ends the run when neither channel nor the register port moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("substitution_sequence_generator_core_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: short random stall bursts, one long hold on request, none when quiet.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                i_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the tick is taken.
    task automatic send_tick(input logic restart);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (o_stall);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // Drains every outstanding word, then waits out ticks that produce nothing.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_rule(input logic [3:0] rule);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RULE_ADDR;
        pwdata  <= {28'($urandom_range(0, 32'h0fff_ffff)), rule};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rule_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin : stimulus
        int         random_ticks;
        int         run_len;
        logic [3:0] rule;
        logic       first_run;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Before any restart the tape is exhausted; then a restart under the
        // reset rule, followed by a restart and one plain tick under each rule.
        send_tick(1'b0);
        send_tick(1'b1);
        for (int r = RULE_FIB; r <= RULE_NONAUTO; r++) begin
            settle();
            write_rule(4'(r));
            send_tick(1'b1);
            send_tick(1'b0);
        end
        settle();
        write_rule(RULE_UNUSED_HI);
        send_tick(1'b1);
        settle();
        write_rule(RULE_UNUSED_LO);
        send_tick(1'b1);

        // Cantor writes three words per tick, so one run covers the whole tape
        // and keeps emitting past its end, while the receiver holds off and
        // backs the core up.
        settle();
        write_rule(RULE_CANTOR);
        long_hold_req = 1'b1;
        send_tick(1'b1);
        repeat (FILL_TICKS - 1) send_tick(1'b0);

        // Random runs: every entry is written now, so rule changes without a
        // restart are safe and expose symbols that the new rule leaves alone.
        random_ticks = 0;
        first_run    = 1'b1;
        while (random_ticks < RANDOM_TICKS) begin
            settle();
            if ($urandom_range(0, 6) == 0) rule = 4'($urandom_range(RULE_UNUSED_LO, RULE_UNUSED_HI));
            else                           rule = 4'($urandom_range(RULE_FIB, RULE_NONAUTO));
            write_rule(rule);
            run_len = $urandom_range(4, 16);
            for (int k = 0; k < run_len && random_ticks < RANDOM_TICKS; k++) begin
                if (k == 0) send_tick(first_run || $urandom_range(0, 3) != 0);
                else        send_tick($urandom_range(0, 11) == 0);
                random_ticks++;
                if (random_ticks >= RANDOM_TICKS - QUIET_TAIL) quiet = 1'b1;
            end
            first_run = 1'b0;
        end
        settle();

        $display("covered %0d ticks over %0d rule writes, including a run past a full tape",
                 ticks_sent, rule_writes);
        $display("%0d symbol words compared under random stalls and one long output hold",
                 words_checked);
        if (mismatches == 0) begin
            $display("substitution_sequence_generator_core_test: clean");
        end else begin
            $display("substitution_sequence_generator_core_test: errors");
        end
        $finish;
    end

endmodule

// File: substitution_sequence_generator_core.f
rtl/core/ssg_pkg.sv
rtl/core/ssg_front.sv
rtl/core/ssg_expand.sv
rtl/core/ssg_outq.sv
rtl/core/substitution_sequence_generator_core.sv
tb/ssg_symbol_checker.sv
tb/substitution_sequence_generator_core_test.sv
